### src/dhf_pkg.sv
// ----------------------------------------------------------------------------
// dhf_pkg
// Types and constants shared by the duplicate hash filter cache.
// ----------------------------------------------------------------------------
package dhf_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int HASH_BYTES_DEF = 4;

  localparam int CMD_W   = 2;
  localparam int HASH_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [HASH_W-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] valid_count;
  } out_item_t;

  typedef struct packed {
    logic shift_en;
  } cell_ctl_t;

endpackage

### src/dhf_cell.sv
// ----------------------------------------------------------------------------
// dhf_cell
// One entry of the hash chain: holds a hash, hands it to the next cell on
// insert and compares it against the lookup key.
// ----------------------------------------------------------------------------
module dhf_cell
  import dhf_pkg::*;
#(
  parameter int KEY_W = 32,
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] din,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] cnt,
  output logic [KEY_W-1:0] dout,
  output logic             match
);

  logic [KEY_W-1:0] hash_r;
  logic             valid;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      hash_r <= din;
    end
  end

  // entries are ordered newest first, so index below count means valid
  assign valid = CNT_W'(IDX) < cnt;
  assign match = valid && (hash_r == key);
  assign dout  = hash_r;

endmodule

### src/duplicate_hash_filter_cache.sv
// ----------------------------------------------------------------------------
// duplicate_hash_filter_cache
// Result: registered in the cycle after the item is accepted.
// Throughput: one item per cycle unless out_ready stalls; all cells compare
// in parallel, the chain shifts per insert, the output register sets the pace.
// Reset: clears the entry count and output valid; stored hashes are not reset.
// ----------------------------------------------------------------------------
module duplicate_hash_filter_cache
  import dhf_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int KEY_W = (8 * HASH_BYTES > HASH_W) ? HASH_W : 8 * HASH_BYTES;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             in_fire;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  cell_ctl_t        ctl;
  logic [KEY_W-1:0] chain [DEPTH];
  logic [DEPTH-1:0] match;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign key      = in_data.hash_value[KEY_W-1:0];

  assign ctl.shift_en = in_fire && (in_data.command == CMD_INSERT);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] din;
    if (i == 0) begin : g_head
      assign din = key;
    end else begin : g_link
      assign din = chain[i-1];
    end
    dhf_cell #(
      .KEY_W (KEY_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .din   (din),
      .key   (key),
      .cnt   (count_r),
      .dout  (chain[i]),
      .match (match[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_data_nxt.hit = 1'b0;
      unique case (in_data.command)
        CMD_LOOKUP: out_data_nxt.hit = |match;
        CMD_INSERT: begin
          if (count_r != CNT_W'(DEPTH)) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_CLEAR:  count_nxt = '0;
        default:    ;
      endcase
      out_data_nxt.valid_count = COUNT_W'(count_nxt);
      out_valid_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.command == CMD_CLEAR) |=> count_r == '0)
    else $error("clear left entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.command == CMD_INSERT) && (count_r != CNT_W'(DEPTH))
    |=> count_r == CNT_W'($past(count_r) + CNT_W'(1)))
    else $error("insert did not grow count");

  a_insert_then_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.command == CMD_LOOKUP)
    && $past(in_fire && (in_data.command == CMD_INSERT) && rst_n)
    && (key == $past(key))
    |=> out_data_r.hit)
    else $error("lookup missed a just inserted hash");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
